// ===== hw/rtl/lte_pkg.sv =====
// shared types, grid geometry and operation codes for the life engine
package lte_pkg;

  localparam int GRID_WIDTH  = 80;
  localparam int GRID_HEIGHT = 24;

  localparam int X_W    = $clog2(GRID_WIDTH);
  localparam int ROW_W  = $clog2(GRID_HEIGHT);
  localparam int ADDR_W = $clog2(2 * GRID_HEIGHT);
  localparam int STEP_W = $clog2(GRID_HEIGHT + 3);

  // neighbor counts of the b3/s23 rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  typedef logic [GRID_WIDTH-1:0] row_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] cell_x;
    logic [4:0] cell_y;
    logic       cell_value;
  } lte_in_t;

  typedef struct packed {
    logic        cell_alive;
    logic [3:0]  neighbour_count;
    logic [31:0] generation;
  } lte_out_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [ROW_W-1:0] row;
  } lte_rd_req_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [ROW_W-1:0] row;
    row_t             data;
  } lte_wr_req_t;

  function automatic logic [ADDR_W-1:0] bank_addr(input logic bank,
                                                  input logic [ROW_W-1:0] row);
    logic [ADDR_W-1:0] base;
    base = bank ? ADDR_W'(GRID_HEIGHT) : '0;
    return base + ADDR_W'(row);
  endfunction

endpackage

// ===== hw/rtl/lte_grid_mem.sv =====
// row-wide grid memory holding both ping-pong buffers, with per-row valid bits
module lte_grid_mem (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  lte_pkg::lte_rd_req_t rd,
  input  lte_pkg::lte_wr_req_t wr,
  output lte_pkg::row_t      rd_data
);
  import lte_pkg::*;

  row_t              mem [0:2*GRID_HEIGHT-1];
  logic [2*GRID_HEIGHT-1:0] row_ok;
  row_t              q;
  logic              q_ok;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;

  assign raddr = bank_addr(rd.bank, rd.row);
  assign waddr = bank_addr(wr.bank, wr.row);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
    if (rd.en) begin
      q <= mem[raddr];
    end
  end

  // a row never written since reset or clear reads as all dead
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_ok <= '0;
    end else if (wr.en) begin
      row_ok[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ok <= 1'b0;
    end else if (rd.en) begin
      q_ok <= row_ok[raddr];
    end
  end

  assign rd_data = q_ok ? q : '0;

endmodule

// ===== hw/rtl/lte_row_rule.sv =====
// b3/s23 next-row computation and single-cell neighbor lookup over a three-row window
module lte_row_rule (
  input  lte_pkg::row_t            above,
  input  lte_pkg::row_t            center,
  input  lte_pkg::row_t            below,
  input  logic [lte_pkg::X_W-1:0]  x,
  output lte_pkg::row_t            next_row,
  output logic                     alive,
  output logic [3:0]               count
);
  import lte_pkg::*;

  for (genvar i = 0; i < GRID_WIDTH; i++) begin : g_cell
    localparam int L = (i + GRID_WIDTH - 1) % GRID_WIDTH;
    localparam int R = (i + 1) % GRID_WIDTH;
    logic [3:0] n;
    assign n = 4'(above[L]) + 4'(above[i]) + 4'(above[R])
             + 4'(center[L]) + 4'(center[R])
             + 4'(below[L]) + 4'(below[i]) + 4'(below[R]);
    assign next_row[i] = (n == BIRTH_COUNT) || (center[i] && (n == SURVIVE_COUNT));
  end

  logic [X_W-1:0] xl;
  logic [X_W-1:0] xr;

  // wrap at the left and right edges
  assign xl = (x == '0) ? X_W'(GRID_WIDTH - 1) : x - X_W'(1);
  assign xr = (x == X_W'(GRID_WIDTH - 1)) ? '0 : x + X_W'(1);

  assign alive = center[x];
  assign count = 4'(above[xl]) + 4'(above[x]) + 4'(above[xr])
               + 4'(center[xl]) + 4'(center[xr])
               + 4'(below[xl]) + 4'(below[x]) + 4'(below[xr]);

endmodule

// ===== hw/rtl/life_torus_generation_engine_unit.sv =====
// top level of the toroidal life engine: sequencer, result register and checks
//
// channel  | payload    | handshake                | direction
// in_*     | lte_in_t   | in_valid / in_stall      | into the block
// out_*    | lte_out_t  | out_valid / out_stall    | out of the block
//
// one transaction at a time; an off-grid read, write or clear skips the row accesses of its cell.
// an advance streams GRID_HEIGHT+2 rows through the single memory read port while each new row
// is written to the other buffer, and then looks up the cell as a read does.
// reset clears the row valid bits at once, so the grid reads dead with no sweep.
// a new transaction is taken while the previous result still waits under out_stall.
module life_torus_generation_engine_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lte_pkg::lte_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lte_pkg::lte_out_t out_data
);
  import lte_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RMW  = 3'd1;
  localparam logic [2:0] S_GEN  = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [STEP_W-1:0] GEN_LAST      = STEP_W'(GRID_HEIGHT + 2);
  localparam logic [STEP_W-1:0] GEN_READ_LAST = STEP_W'(GRID_HEIGHT + 1);
  localparam logic [STEP_W-1:0] WIN_FULL      = STEP_W'(3);

  logic [2:0]        state;
  logic [STEP_W-1:0] step;
  lte_in_t           item;
  logic              active;
  logic [31:0]       gen_count;
  logic              rd_pend;
  row_t              w0;
  row_t              w1;
  logic              res_alive;
  logic [3:0]        res_count;

  lte_rd_req_t       rd;
  lte_wr_req_t       wr;
  row_t              rd_data;
  logic              mem_clear;
  logic              in_accept;
  logic              on_grid;
  logic [ROW_W-1:0]  cell_row;
  logic [ROW_W-1:0]  row_up;
  logic [ROW_W-1:0]  row_down;
  logic [ROW_W-1:0]  gen_row;
  logic [STEP_W-1:0] step_m1;
  logic [X_W-1:0]    cell_col;
  row_t              rule_next;
  logic              rule_alive;
  logic [3:0]        rule_count;
  row_t              patched;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign mem_clear = in_accept && (in_data.mode == MODE_CLEAR);

  assign on_grid  = (32'(item.cell_x) < 32'(GRID_WIDTH)) && (32'(item.cell_y) < 32'(GRID_HEIGHT));
  assign cell_row = ROW_W'(item.cell_y);
  assign cell_col = X_W'(item.cell_x);
  assign row_up   = (cell_row == '0) ? ROW_W'(GRID_HEIGHT - 1) : cell_row - ROW_W'(1);
  assign row_down = (cell_row == ROW_W'(GRID_HEIGHT - 1)) ? '0 : cell_row + ROW_W'(1);

  // advance read order: last row, then rows 0 .. last, then row 0 again
  assign step_m1 = step - STEP_W'(1);
  always_comb begin
    if (step == '0) begin
      gen_row = ROW_W'(GRID_HEIGHT - 1);
    end else if (step_m1 < STEP_W'(GRID_HEIGHT)) begin
      gen_row = ROW_W'(step_m1);
    end else begin
      gen_row = '0;
    end
  end

  always_comb begin
    patched = rd_data;
    patched[cell_col] = item.cell_value;
  end

  always_comb begin
    rd = '0;
    wr = '0;
    unique case (state)
      S_RMW: begin
        if (on_grid && (step == '0)) begin
          rd.en   = 1'b1;
          rd.bank = active;
          rd.row  = cell_row;
        end else if (on_grid) begin
          wr.en   = 1'b1;
          wr.bank = active;
          wr.row  = cell_row;
          wr.data = patched;
        end
      end
      S_GEN: begin
        if (step <= GEN_READ_LAST) begin
          rd.en   = 1'b1;
          rd.bank = active;
          rd.row  = gen_row;
        end
        if (step >= WIN_FULL) begin
          wr.en   = 1'b1;
          wr.bank = !active;
          wr.row  = ROW_W'(step - WIN_FULL);
          wr.data = rule_next;
        end
      end
      S_LOOK: begin
        if (on_grid && (step < WIN_FULL)) begin
          rd.en   = 1'b1;
          rd.bank = active;
          unique case (step[1:0])
            2'd0:    rd.row = row_up;
            2'd1:    rd.row = cell_row;
            default: rd.row = row_down;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  lte_grid_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (mem_clear),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rd_data)
  );

  lte_row_rule u_rule (
    .above    (w0),
    .center   (w1),
    .below    (rd_data),
    .x        (cell_col),
    .next_row (rule_next),
    .alive    (rule_alive),
    .count    (rule_count)
  );

  // row window slides by one each time read data arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd.en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      w0 <= w1;
      w1 <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      active    <= 1'b0;
      gen_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            step <= '0;
            unique case (in_data.mode)
              MODE_CLEAR: begin
                gen_count <= '0;
                state     <= S_LOOK;
              end
              MODE_WRITE:   state <= S_RMW;
              MODE_ADVANCE: state <= S_GEN;
              MODE_READ:    state <= S_LOOK;
            endcase
          end
        end
        S_RMW: begin
          if (!on_grid) begin
            state <= S_LOOK;
          end else if (step == '0) begin
            step <= STEP_W'(1);
          end else begin
            step  <= '0;
            state <= S_LOOK;
          end
        end
        S_GEN: begin
          if (step == GEN_LAST) begin
            active    <= !active;
            gen_count <= gen_count + 32'd1;
            step      <= '0;
            state     <= S_LOOK;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_LOOK: begin
          if (!on_grid || (step == WIN_FULL)) begin
            state <= S_DONE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an off-grid cell reports dead with no neighbors
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item <= in_data;
    end
    if (state == S_LOOK) begin
      if (!on_grid) begin
        res_alive <= 1'b0;
        res_count <= '0;
      end else if (step == WIN_FULL) begin
        res_alive <= rule_alive;
        res_count <= rule_count;
      end
    end
    if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      out_data.cell_alive      <= res_alive;
      out_data.neighbour_count <= res_count;
      out_data.generation      <= gen_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // the rule pass must never overwrite the buffer it is reading
  a_gen_writes_other_bank: assert property (@(posedge clk) disable iff (rst)
    (wr.en && (state == S_GEN)) |-> (wr.bank != active))
    else $error("advance wrote into the current buffer");

  // buffers swap only at the end of an advance
  a_swap_only_after_gen: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (active != $past(active))) |-> ($past(state) == S_GEN))
    else $error("buffer swap outside an advance");

  a_gen_count_step: assert property (@(posedge clk) disable iff (rst)
    ((state == S_GEN) && (step == GEN_LAST)) |=> (gen_count == $past(gen_count) + 32'd1))
    else $error("generation count did not step by one");

  a_off_grid_zero: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && !on_grid) |-> (!res_alive && (res_count == 4'd0)))
    else $error("off-grid transaction reported a live cell or neighbors");

endmodule
